@@ design/rtn_pkg.sv @@
`timescale 1ns / 1ps

package rtn_pkg;

  // Configuration port layout.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BLUE_FIRST   = 2'd2;

  localparam logic [CFG_DATA_W-1:0] FRAME_WIDTH_RST  = 13'd640;
  localparam logic [CFG_DATA_W-1:0] FRAME_HEIGHT_RST = 13'd480;
  localparam logic                  BLUE_FIRST_RST   = 1'b1;

  // Frame size limits.
  localparam int DEFAULT_MAX_WIDTH  = 4096;
  localparam int DEFAULT_MAX_HEIGHT = 4096;
  localparam int MIN_SIZE           = 2;

  // Result fields.
  localparam int BYTE_W   = 8;
  localparam int OFFSET_W = 25;

  // Depth of the job queue between the front and back parts.
  localparam int JOB_DEPTH = 4;

  typedef enum logic [1:0] {
    PLANE_Y = 2'd0,
    PLANE_U = 2'd1,
    PLANE_V = 2'd2
  } plane_t;

  typedef struct packed {
    logic [BYTE_W-1:0] r;
    logic [BYTE_W-1:0] g;
    logic [BYTE_W-1:0] b;
  } rgb_t;

  typedef struct packed {
    logic [BYTE_W:0] r;
    logic [BYTE_W:0] g;
    logic [BYTE_W:0] b;
  } pair_sum_t;

  // One classified pixel, handed from the front part to the back part.
  typedef struct packed {
    rgb_t                pix;
    rgb_t                avg;
    logic                block_end;
    logic                last_pixel;
    logic [OFFSET_W-1:0] luma_off;
    logic [OFFSET_W-1:0] chroma_off;
  } job_t;

endpackage

@@ design/rtn_front.sv @@
`timescale 1ns / 1ps

module rtn_front #(
  parameter int MAX_WIDTH  = rtn_pkg::DEFAULT_MAX_WIDTH,
  parameter int MAX_HEIGHT = rtn_pkg::DEFAULT_MAX_HEIGHT
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_push,
  input  logic [rtn_pkg::BYTE_W-1:0]     in_chan_first,
  input  logic [rtn_pkg::BYTE_W-1:0]     in_chan_second,
  input  logic [rtn_pkg::BYTE_W-1:0]     in_chan_third,
  output logic                           in_full,
  input  logic [rtn_pkg::CFG_DATA_W-1:0] width_cfg,
  input  logic [rtn_pkg::CFG_DATA_W-1:0] height_cfg,
  input  logic                           blue_first,
  input  logic                           restart,
  output logic                           job_push,
  output rtn_pkg::job_t                  job,
  input  logic                           job_full
);
  import rtn_pkg::*;

  localparam int CW      = $clog2(MAX_WIDTH);
  localparam int RW      = $clog2(MAX_HEIGHT);
  localparam int WW      = $clog2(MAX_WIDTH + 1);
  localparam int HW      = $clog2(MAX_HEIGHT + 1);
  localparam int W_LIM   = (MAX_WIDTH / 2) * 2;
  localparam int H_LIM   = (MAX_HEIGHT / 2) * 2;
  localparam int L_DEPTH = MAX_WIDTH / 2;
  localparam int PW      = (L_DEPTH > 1) ? $clog2(L_DEPTH) : 1;

  logic [CFG_DATA_W-1:0] w_even, h_even;
  logic [WW-1:0]         w_eff;
  logic [HW-1:0]         h_eff;
  logic [WW+HW-1:0]      wh_full;
  logic [OFFSET_W-1:0]   wh_r;

  logic [CW-1:0]       col_r, col_nxt;
  logic [RW-1:0]       row_r, row_nxt;
  logic [OFFSET_W-1:0] pix_idx_r, pix_idx_nxt;
  logic [OFFSET_W-1:0] chroma_rel_r, chroma_rel_nxt;
  rgb_t                left_r, left_nxt;

  logic      accept, col_last, row_last, odd_col, odd_row;
  rgb_t      pix;
  pair_sum_t bottom;
  logic [PW-1:0] pair_addr;

  pair_sum_t line_mem [L_DEPTH];
  pair_sum_t top_q_r;

  logic                b_valid_r, b_valid_nxt;
  rgb_t                b_pix_r;
  pair_sum_t           b_sum_r;
  logic                b_block_end_r;
  logic                b_last_r;
  logic [OFFSET_W-1:0] b_luma_r;
  logic [OFFSET_W-1:0] b_crel_r;

  // Effective frame size: even, at least two, at most the build limit.
  assign w_even = {width_cfg[CFG_DATA_W-1:1], 1'b0};
  assign h_even = {height_cfg[CFG_DATA_W-1:1], 1'b0};

  always_comb begin
    if (w_even < CFG_DATA_W'(MIN_SIZE)) begin
      w_eff = WW'(MIN_SIZE);
    end else if (32'(w_even) > W_LIM) begin
      w_eff = WW'(W_LIM);
    end else begin
      w_eff = WW'(w_even);
    end
  end

  always_comb begin
    if (h_even < CFG_DATA_W'(MIN_SIZE)) begin
      h_eff = HW'(MIN_SIZE);
    end else if (32'(h_even) > H_LIM) begin
      h_eff = HW'(H_LIM);
    end else begin
      h_eff = HW'(h_even);
    end
  end

  assign wh_full = (WW+HW)'(w_eff) * (WW+HW)'(h_eff);

  always_ff @(posedge clk) begin
    wh_r <= OFFSET_W'(wh_full);
  end

  // Stage A: accept, classify and touch the line store.
  assign in_full  = b_valid_r && job_full;
  assign accept   = in_push && !in_full;
  assign job_push = b_valid_r && !job_full;

  assign pix.r = blue_first ? in_chan_third : in_chan_first;
  assign pix.g = in_chan_second;
  assign pix.b = blue_first ? in_chan_first : in_chan_third;

  assign col_last  = WW'(col_r) == (w_eff - WW'(1));
  assign row_last  = HW'(row_r) == (h_eff - HW'(1));
  assign odd_col   = col_r[0];
  assign odd_row   = row_r[0];
  assign pair_addr = PW'(col_r >> 1);

  assign bottom.r = (BYTE_W+1)'(left_r.r) + (BYTE_W+1)'(pix.r);
  assign bottom.g = (BYTE_W+1)'(left_r.g) + (BYTE_W+1)'(pix.g);
  assign bottom.b = (BYTE_W+1)'(left_r.b) + (BYTE_W+1)'(pix.b);

  always_comb begin
    col_nxt        = col_r;
    row_nxt        = row_r;
    pix_idx_nxt    = pix_idx_r;
    chroma_rel_nxt = chroma_rel_r;
    left_nxt       = left_r;
    if (restart) begin
      col_nxt        = '0;
      row_nxt        = '0;
      pix_idx_nxt    = '0;
      chroma_rel_nxt = '0;
      left_nxt       = '0;
    end else if (accept) begin
      if (!odd_col) begin
        left_nxt = pix;
      end
      if (col_last) begin
        col_nxt = '0;
        if (row_last) begin
          row_nxt        = '0;
          pix_idx_nxt    = '0;
          chroma_rel_nxt = '0;
        end else begin
          row_nxt     = row_r + RW'(1);
          pix_idx_nxt = pix_idx_r + OFFSET_W'(1);
          if (odd_row) begin
            chroma_rel_nxt = chroma_rel_r + OFFSET_W'(w_eff);
          end
        end
      end else begin
        col_nxt     = col_r + CW'(1);
        pix_idx_nxt = pix_idx_r + OFFSET_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r        <= '0;
      row_r        <= '0;
      pix_idx_r    <= '0;
      chroma_rel_r <= '0;
      left_r       <= '0;
    end else begin
      col_r        <= col_nxt;
      row_r        <= row_nxt;
      pix_idx_r    <= pix_idx_nxt;
      chroma_rel_r <= chroma_rel_nxt;
      left_r       <= left_nxt;
    end
  end

  // The upper row of a block writes its pair sums, the lower row reads them.
  always_ff @(posedge clk) begin
    if (accept && odd_col && !odd_row) begin
      line_mem[pair_addr] <= bottom;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && odd_col && odd_row) begin
      top_q_r <= line_mem[pair_addr];
    end
  end

  // Stage B: finish the block averages and the chroma offset.
  assign b_valid_nxt = accept ? 1'b1 : (job_push ? 1'b0 : b_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else begin
      b_valid_r <= b_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      b_pix_r       <= pix;
      b_sum_r       <= bottom;
      b_block_end_r <= odd_col && odd_row;
      b_last_r      <= col_last && row_last;
      b_luma_r      <= pix_idx_r;
      b_crel_r      <= chroma_rel_r + (OFFSET_W'(col_r >> 1) << 1);
    end
  end

  always_comb begin
    job.pix        = b_pix_r;
    job.avg.r      = BYTE_W'(((BYTE_W+2)'(b_sum_r.r) + (BYTE_W+2)'(top_q_r.r)) >> 2);
    job.avg.g      = BYTE_W'(((BYTE_W+2)'(b_sum_r.g) + (BYTE_W+2)'(top_q_r.g)) >> 2);
    job.avg.b      = BYTE_W'(((BYTE_W+2)'(b_sum_r.b) + (BYTE_W+2)'(top_q_r.b)) >> 2);
    job.block_end  = b_block_end_r;
    job.last_pixel = b_last_r;
    job.luma_off   = b_luma_r;
    job.chroma_off = wh_r + b_crel_r;
  end

endmodule

@@ design/rtn_job_fifo.sv @@
`timescale 1ns / 1ps

module rtn_job_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  rtn_pkg::job_t push_job,
  output logic          full,
  input  logic          pop,
  output rtn_pkg::job_t head_job,
  output logic          empty
);
  import rtn_pkg::*;

  localparam int PTR_W = (JOB_DEPTH > 1) ? $clog2(JOB_DEPTH) : 1;
  localparam int CNT_W = $clog2(JOB_DEPTH + 1);

  job_t             slot_r [JOB_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full     = count_r == CNT_W'(JOB_DEPTH);
  assign empty    = count_r == '0;
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign head_job = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(JOB_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(JOB_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

@@ design/rtn_back.sv @@
`timescale 1ns / 1ps

module rtn_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  rtn_pkg::job_t                head_job,
  input  logic                         job_empty,
  output logic                         job_pop,
  output logic                         out_empty,
  input  logic                         out_pop,
  output logic [rtn_pkg::BYTE_W-1:0]   out_byte,
  output logic [rtn_pkg::OFFSET_W-1:0] out_byte_offset,
  output logic [1:0]                   out_plane_kind,
  output logic                         out_last_of_run,
  output logic                         out_frame_done
);
  import rtn_pkg::*;

  localparam int ACC_W = 17;

  localparam logic [ACC_W-1:0] KY_R        = 17'd66;
  localparam logic [ACC_W-1:0] KY_G        = 17'd129;
  localparam logic [ACC_W-1:0] KY_B        = 17'd25;
  localparam logic [ACC_W-1:0] ROUND_HALF  = 17'd128;
  localparam logic [ACC_W-1:0] LUMA_FLOOR  = 17'd16;
  localparam logic [ACC_W-1:0] KU_R        = 17'd38;
  localparam logic [ACC_W-1:0] KU_G        = 17'd74;
  localparam logic [ACC_W-1:0] K_112       = 17'd112;
  localparam logic [ACC_W-1:0] KV_G        = 17'd94;
  localparam logic [ACC_W-1:0] KV_B        = 17'd18;
  localparam logic [ACC_W-1:0] CHROMA_BIAS = 17'd32896;

  // The luma sum tops out at 235, so no clamp is needed.
  function automatic logic [BYTE_W-1:0] luma_of(input rgb_t p);
    logic [ACC_W-1:0] acc;
    acc = ACC_W'(p.r) * KY_R + ACC_W'(p.g) * KY_G + ACC_W'(p.b) * KY_B + ROUND_HALF;
    return BYTE_W'((acc >> 8) + LUMA_FLOOR);
  endfunction

  // Both chroma sums, biased by 128.5 * 256, stay within 4336..61456, so
  // the byte is simply bits 15:8 and never needs clamping.
  function automatic logic [BYTE_W-1:0] cb_of(input rgb_t a);
    logic [ACC_W-1:0] acc;
    acc = ACC_W'(a.b) * K_112 + CHROMA_BIAS - ACC_W'(a.r) * KU_R - ACC_W'(a.g) * KU_G;
    return BYTE_W'(acc >> 8);
  endfunction

  function automatic logic [BYTE_W-1:0] cr_of(input rgb_t a);
    logic [ACC_W-1:0] acc;
    acc = ACC_W'(a.r) * K_112 + CHROMA_BIAS - ACC_W'(a.g) * KV_G - ACC_W'(a.b) * KV_B;
    return BYTE_W'(acc >> 8);
  endfunction

  plane_t              plane_r, plane_nxt;
  logic                j_valid_r, j_valid_nxt;
  logic [BYTE_W-1:0]   y_r, u_r, v_r;
  logic                blk_r, last_px_r;
  logic [OFFSET_W-1:0] luma_off_r, chroma_off_r;

  logic                out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0]   out_byte_r;
  logic [OFFSET_W-1:0] out_off_r;
  plane_t              out_kind_r;
  logic                out_last_r, out_done_r;

  logic                slot_free, emit, job_done;
  logic [BYTE_W-1:0]   emit_byte;
  logic [OFFSET_W-1:0] emit_off;
  logic                emit_last, emit_done;

  assign slot_free = !out_valid_r || out_pop;
  assign emit      = j_valid_r && slot_free;
  assign job_done  = emit && (((plane_r == PLANE_Y) && !blk_r) || (plane_r == PLANE_V));
  assign job_pop   = !job_empty && (!j_valid_r || job_done);

  // Next state of the sequencer.
  always_comb begin
    plane_nxt = plane_r;
    if (emit) begin
      case (plane_r)
        PLANE_Y: plane_nxt = blk_r ? PLANE_U : PLANE_Y;
        PLANE_U: plane_nxt = PLANE_V;
        PLANE_V: plane_nxt = PLANE_Y;
        default: plane_nxt = PLANE_Y;
      endcase
    end
  end

  // Item that the current state offers to the output register.
  always_comb begin
    case (plane_r)
      PLANE_Y: begin
        emit_byte = y_r;
        emit_off  = luma_off_r;
        emit_last = !blk_r;
        emit_done = !blk_r && last_px_r;
      end
      PLANE_U: begin
        emit_byte = u_r;
        emit_off  = chroma_off_r;
        emit_last = 1'b0;
        emit_done = 1'b0;
      end
      PLANE_V: begin
        emit_byte = v_r;
        emit_off  = chroma_off_r + OFFSET_W'(1);
        emit_last = 1'b1;
        emit_done = last_px_r;
      end
      default: begin
        emit_byte = y_r;
        emit_off  = luma_off_r;
        emit_last = 1'b1;
        emit_done = 1'b0;
      end
    endcase
  end

  assign j_valid_nxt   = job_pop ? 1'b1 : (job_done ? 1'b0 : j_valid_r);
  assign out_valid_nxt = emit ? 1'b1 : (out_pop ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plane_r     <= PLANE_Y;
      j_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      plane_r     <= plane_nxt;
      j_valid_r   <= j_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (job_pop) begin
      y_r          <= luma_of(head_job.pix);
      u_r          <= cb_of(head_job.avg);
      v_r          <= cr_of(head_job.avg);
      blk_r        <= head_job.block_end;
      last_px_r    <= head_job.last_pixel;
      luma_off_r   <= head_job.luma_off;
      chroma_off_r <= head_job.chroma_off;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte_r <= emit_byte;
      out_off_r  <= emit_off;
      out_kind_r <= plane_r;
      out_last_r <= emit_last;
      out_done_r <= emit_done;
    end
  end

  assign out_empty       = !out_valid_r;
  assign out_byte        = out_byte_r;
  assign out_byte_offset = out_off_r;
  assign out_plane_kind  = out_kind_r;
  assign out_last_of_run = out_last_r;
  assign out_frame_done  = out_done_r;

endmodule

@@ design/rgb_to_nv12_converter.sv @@
`timescale 1ns / 1ps

// Channel        Handshake            Payload
// -------------  -------------------  ----------------------------------------------
// pixel in       in_push / in_full    in_chan_first, in_chan_second, in_chan_third
// result out     out_pop / out_empty  out_byte, out_byte_offset, out_plane_kind,
//                                     out_last_of_run, out_frame_done
// configuration  cfg_wr_en            cfg_index, cfg_data
//
// The front part takes one pixel per cycle while in_full is low; the back part sends
// one byte per cycle while out_pop keeps its single output register free, which sets
// the throughput. A pixel yields one byte, or three when it closes a 2x2 block. Its
// first byte is held in stage B, the job queue, y_r and out_byte_r before it shows.
// Reset (synchronous, active low) loads 640x480 BGR and empties all queues; the line
// store is not cleared, since each entry is written on a block's upper row first.
// Either side may stall at any time: a four-entry job queue lets the front keep
// accepting while the back waits on out_pop.

module rgb_to_nv12_converter #(
  parameter int MAX_WIDTH  = rtn_pkg::DEFAULT_MAX_WIDTH,
  parameter int MAX_HEIGHT = rtn_pkg::DEFAULT_MAX_HEIGHT
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_push,
  output logic                           in_full,
  input  logic [rtn_pkg::BYTE_W-1:0]     in_chan_first,
  input  logic [rtn_pkg::BYTE_W-1:0]     in_chan_second,
  input  logic [rtn_pkg::BYTE_W-1:0]     in_chan_third,
  output logic                           out_empty,
  input  logic                           out_pop,
  output logic [rtn_pkg::BYTE_W-1:0]     out_byte,
  output logic [rtn_pkg::OFFSET_W-1:0]   out_byte_offset,
  output logic [1:0]                     out_plane_kind,
  output logic                           out_last_of_run,
  output logic                           out_frame_done,
  input  logic                           cfg_wr_en,
  input  logic [rtn_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rtn_pkg::CFG_DATA_W-1:0] cfg_data
);
  import rtn_pkg::*;

  // Configuration registers. A write to either size register restarts the
  // frame from its top left pixel; a write to the order register only
  // affects pixels accepted after it.
  logic [CFG_DATA_W-1:0] width_cfg_r;
  logic [CFG_DATA_W-1:0] height_cfg_r;
  logic                  blue_first_r;
  logic                  restart;

  assign restart = cfg_wr_en &&
                   ((cfg_index == REG_FRAME_WIDTH) || (cfg_index == REG_FRAME_HEIGHT));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_cfg_r  <= FRAME_WIDTH_RST;
      height_cfg_r <= FRAME_HEIGHT_RST;
      blue_first_r <= BLUE_FIRST_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_FRAME_WIDTH:  width_cfg_r  <= cfg_data;
        REG_FRAME_HEIGHT: height_cfg_r <= cfg_data;
        REG_BLUE_FIRST:   blue_first_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Front part: counts position, keeps the line store and forms block averages.
  job_t job_in, job_head;
  logic job_push, job_full, job_pop, job_empty;

  rtn_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_chan_first  (in_chan_first),
    .in_chan_second (in_chan_second),
    .in_chan_third  (in_chan_third),
    .in_full        (in_full),
    .width_cfg      (width_cfg_r),
    .height_cfg     (height_cfg_r),
    .blue_first     (blue_first_r),
    .restart        (restart),
    .job_push       (job_push),
    .job            (job_in),
    .job_full       (job_full)
  );

  // Job queue between the two parts.
  rtn_job_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (job_push),
    .push_job (job_in),
    .full     (job_full),
    .pop      (job_pop),
    .head_job (job_head),
    .empty    (job_empty)
  );

  // Back part: converts each job into its luma byte and, at block ends, the
  // two chroma bytes, one item per cycle while out_pop keeps the output register free.
  rtn_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head_job        (job_head),
    .job_empty       (job_empty),
    .job_pop         (job_pop),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_byte        (out_byte),
    .out_byte_offset (out_byte_offset),
    .out_plane_kind  (out_plane_kind),
    .out_last_of_run (out_last_of_run),
    .out_frame_done  (out_frame_done)
  );

  // The front never pushes a job into a full queue.
  assert property (@(posedge clk) disable iff (!rst_n) !(job_push && job_full))
    else $error("job pushed into a full queue");

  // The end of a frame is always the last item of its pixel.
  assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_frame_done) |-> out_last_of_run)
    else $error("frame end without end of run");

  // A U item taken is followed at once by its V item.
  assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_pop && (out_plane_kind == PLANE_U)) |=>
    (!out_empty && (out_plane_kind == PLANE_V)))
    else $error("U item not followed by V item");

endmodule
